FILE: rtl/core/nrat_pkg.sv
// ----------------------------------------------------------------------------
// nrat_pkg: shared types and constants of the neighbour RSSI average table
// Field widths, item kinds, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package nrat_pkg;

  localparam int ID_W    = 16;
  localparam int COUNT_W = 16;
  localparam int SUM_W   = 25;
  localparam int RSSI_W  = 8;
  localparam int ENTRY_W = ID_W + COUNT_W + SUM_W;
  localparam int STEP_W  = $clog2(SUM_W + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic KIND_OBS = 1'b0;
  localparam logic KIND_RPT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OBS_RD,
    ST_OBS_CHK,
    ST_OBS_CLAIM,
    ST_RPT_SCAN,
    ST_RPT_RD,
    ST_RPT_DIV,
    ST_RPT_OUT,
    ST_RPT_EMPTY,
    ST_RPT_CLR
  } nrat_state_t;

  typedef struct packed {
    logic load_item;
    logic idx_clr;
    logic idx_inc;
    logic note_empty;
    logic wr_match;
    logic wr_claim;
    logic div_start;
    logic out_load;
    logic out_load_empty;
    logic tbl_clear;
  } nrat_cmd_t;

  typedef struct packed {
    logic match;
    logic idx_last;
    logic occ_any;
    logic occ_cur;
    logic div_busy;
    logic out_free;
  } nrat_sts_t;

endpackage

FILE: rtl/core/nrat_ram.sv
// ----------------------------------------------------------------------------
// nrat_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module nrat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/nrat_div.sv
// ----------------------------------------------------------------------------
// nrat_div: bit-serial signed-by-unsigned divider
// Restoring division of a signed sum by an unsigned count, one quotient bit
// per cycle, with the quotient truncated toward zero.
// ----------------------------------------------------------------------------
module nrat_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [nrat_pkg::SUM_W-1:0]   dividend,
  input  logic [nrat_pkg::COUNT_W-1:0]        divisor,
  output logic                                busy,
  output logic signed [nrat_pkg::RSSI_W-1:0]  quotient
);
  import nrat_pkg::*;

  logic               busy_r, busy_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [SUM_W-1:0]   mag_r, mag_nxt;
  logic [SUM_W-1:0]   quo_r, quo_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic [COUNT_W-1:0] dvs_r, dvs_nxt;
  logic               neg_r, neg_nxt;
  logic [COUNT_W:0]   rem_sh;
  logic [COUNT_W:0]   rem_dif;
  logic [SUM_W-1:0]   quo_signed;

  assign rem_sh  = {rem_r, mag_r[SUM_W-1]};
  assign rem_dif = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    mag_nxt  = mag_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(SUM_W);
      neg_nxt  = dividend[SUM_W-1];
      mag_nxt  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      quo_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      mag_nxt = {mag_r[SUM_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_dif[COUNT_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[COUNT_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end
      step_nxt = step_r - 1'b1;
      busy_nxt = (step_r != STEP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    step_r <= step_nxt;
    mag_r  <= mag_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    neg_r  <= neg_nxt;
  end

  assign quo_signed = neg_r ? (~quo_r + 1'b1) : quo_r;
  assign quotient   = quo_signed[RSSI_W-1:0];
  assign busy       = busy_r;

endmodule

FILE: rtl/core/nrat_dp.sv
// ----------------------------------------------------------------------------
// nrat_dp: datapath of the neighbour RSSI average table
// Holds the slot memory, the written and occupied flags, the scan index,
// the divider and the output register; acts on controller commands.
// ----------------------------------------------------------------------------
module nrat_dp #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  nrat_pkg::nrat_cmd_t                cmd,
  output nrat_pkg::nrat_sts_t                sts,
  input  logic [nrat_pkg::ID_W-1:0]          in_sender_id,
  input  logic signed [nrat_pkg::RSSI_W-1:0] in_rssi,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic [nrat_pkg::ID_W-1:0]          out_node_id,
  output logic signed [nrat_pkg::RSSI_W-1:0] out_avg_rssi,
  output logic                               out_last,
  output logic                               out_empty_res
);
  import nrat_pkg::*;

  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  logic [ID_W-1:0]          sender_r;
  logic signed [RSSI_W-1:0] rssi_r;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [TABLE_SLOTS-1:0]   wr_bits_r, wr_bits_nxt;
  logic [TABLE_SLOTS-1:0]   occ_r, occ_nxt;
  logic                     empty_found_r, empty_found_nxt;
  logic [IDX_W-1:0]         empty_idx_r, empty_idx_nxt;

  logic [ENTRY_W-1:0]       rd_data;
  logic [ENTRY_W-1:0]       wr_data;
  logic [IDX_W-1:0]         wr_addr;
  logic                     wr_en;
  logic [ID_W-1:0]          eff_id;
  logic [COUNT_W-1:0]       eff_count;
  logic signed [SUM_W-1:0]  eff_sum;
  logic [COUNT_W-1:0]       base_count;
  logic signed [SUM_W-1:0]  base_sum;
  logic signed [SUM_W-1:0]  rssi_ext;
  logic [TABLE_SLOTS-1:0]   upper_mask;

  logic                     div_busy;
  logic signed [RSSI_W-1:0] div_q;

  logic [ID_W-1:0]          node_hold_r;
  logic                     cnt_zero_r;
  logic                     last_hold_r;

  logic                     out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]          out_node_id_r, out_node_id_nxt;
  logic signed [RSSI_W-1:0] out_avg_rssi_r, out_avg_rssi_nxt;
  logic                     out_last_r, out_last_nxt;
  logic                     out_empty_res_r, out_empty_res_nxt;
  logic                     out_free;

  // An entry that was never written since the last clear reads as zero.
  assign eff_id    = wr_bits_r[idx_r] ? rd_data[ENTRY_W-1 -: ID_W] : '0;
  assign eff_count = wr_bits_r[idx_r] ? rd_data[SUM_W +: COUNT_W] : '0;
  assign eff_sum   = wr_bits_r[idx_r] ? signed'(rd_data[SUM_W-1:0]) : '0;

  assign rssi_ext   = SUM_W'(rssi_r);
  assign base_count = (eff_count == COUNT_MAX) ? '0 : eff_count;
  assign base_sum   = (eff_count == COUNT_MAX) ? '0 : eff_sum;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = {sender_r, base_count + 1'b1, base_sum + rssi_ext};
    if (cmd.wr_match) begin
      wr_en = 1'b1;
    end else if (cmd.wr_claim) begin
      wr_en   = empty_found_r;
      wr_addr = empty_idx_r;
      wr_data = {sender_r, COUNT_W'(1), rssi_ext};
    end
  end

  nrat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (idx_r),
    .rdata (rd_data)
  );

  nrat_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (eff_sum),
    .divisor  (eff_count),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_comb begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      upper_mask[i] = (IDX_W'(i) > idx_r);
    end
  end

  always_comb begin
    idx_nxt         = idx_r;
    wr_bits_nxt     = wr_bits_r;
    occ_nxt         = occ_r;
    empty_found_nxt = empty_found_r;
    empty_idx_nxt   = empty_idx_r;
    if (cmd.idx_clr) begin
      idx_nxt         = '0;
      empty_found_nxt = 1'b0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + 1'b1;
    end
    if (cmd.note_empty && !empty_found_r && (eff_id == '0)) begin
      empty_found_nxt = 1'b1;
      empty_idx_nxt   = idx_r;
    end
    if (wr_en) begin
      wr_bits_nxt[wr_addr] = 1'b1;
      occ_nxt[wr_addr]     = (sender_r != '0);
    end
    if (cmd.tbl_clear) begin
      wr_bits_nxt = '0;
      occ_nxt     = '0;
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt     = out_valid_r;
    out_node_id_nxt   = out_node_id_r;
    out_avg_rssi_nxt  = out_avg_rssi_r;
    out_last_nxt      = out_last_r;
    out_empty_res_nxt = out_empty_res_r;
    if (cmd.out_load) begin
      out_valid_nxt     = 1'b1;
      out_node_id_nxt   = node_hold_r;
      out_avg_rssi_nxt  = cnt_zero_r ? '0 : div_q;
      out_last_nxt      = last_hold_r;
      out_empty_res_nxt = 1'b0;
    end else if (cmd.out_load_empty) begin
      out_valid_nxt     = 1'b1;
      out_node_id_nxt   = '0;
      out_avg_rssi_nxt  = '0;
      out_last_nxt      = 1'b1;
      out_empty_res_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_bits_r     <= '0;
      occ_r         <= '0;
      idx_r         <= '0;
      empty_found_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      wr_bits_r     <= wr_bits_nxt;
      occ_r         <= occ_nxt;
      idx_r         <= idx_nxt;
      empty_found_r <= empty_found_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    empty_idx_r     <= empty_idx_nxt;
    out_node_id_r   <= out_node_id_nxt;
    out_avg_rssi_r  <= out_avg_rssi_nxt;
    out_last_r      <= out_last_nxt;
    out_empty_res_r <= out_empty_res_nxt;
    if (cmd.load_item) begin
      sender_r <= in_sender_id;
      rssi_r   <= in_rssi;
    end
    if (cmd.div_start) begin
      node_hold_r <= eff_id;
      cnt_zero_r  <= (eff_count == '0);
      last_hold_r <= ((occ_r & upper_mask) == '0);
    end
  end

  assign sts.match    = (eff_id == sender_r);
  assign sts.idx_last = (idx_r == IDX_W'(TABLE_SLOTS - 1));
  assign sts.occ_any  = (occ_r != '0);
  assign sts.occ_cur  = occ_r[idx_r];
  assign sts.div_busy = div_busy;
  assign sts.out_free = out_free;

  assign out_valid     = out_valid_r;
  assign out_node_id   = out_node_id_r;
  assign out_avg_rssi  = out_avg_rssi_r;
  assign out_last      = out_last_r;
  assign out_empty_res = out_empty_res_r;

  // An occupied slot has always been written since the last clear.
  a_occ_written: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r & ~wr_bits_r) == '0)
    else $error("occupied slot without a write");

  // A report leaves the table empty.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tbl_clear |=> (occ_r == '0) && (wr_bits_r == '0))
    else $error("table not empty after clear");

  // A new result is only loaded when the output register can take it.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load || cmd.out_load_empty) |-> out_free)
    else $error("result loaded over a pending transfer");

  // The divider is never restarted while it is still working.
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy)
    else $error("divider restarted while busy");

  // The empty-report result is the final one and carries no node id.
  a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_res_r) |-> (out_last_r && (out_node_id_r == '0)))
    else $error("malformed empty report result");

endmodule

FILE: rtl/core/nrat_ctrl.sv
// ----------------------------------------------------------------------------
// nrat_ctrl: controller of the neighbour RSSI average table
// Sequences the slot scan of an observation and the listing, division,
// output and clearing steps of a report.
// ----------------------------------------------------------------------------
module nrat_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_kind,
  output logic                in_stall,
  output nrat_pkg::nrat_cmd_t cmd,
  input  nrat_pkg::nrat_sts_t sts
);
  import nrat_pkg::*;

  nrat_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_kind == KIND_RPT) ? ST_RPT_SCAN : ST_OBS_RD;
        end
      end
      ST_OBS_RD: state_nxt = ST_OBS_CHK;
      ST_OBS_CHK: begin
        priority if (sts.match) begin
          state_nxt = ST_IDLE;
        end else if (sts.idx_last) begin
          state_nxt = ST_OBS_CLAIM;
        end else begin
          state_nxt = ST_OBS_RD;
        end
      end
      ST_OBS_CLAIM: state_nxt = ST_IDLE;
      ST_RPT_SCAN: begin
        priority if (!sts.occ_any) begin
          state_nxt = ST_RPT_EMPTY;
        end else if (sts.occ_cur) begin
          state_nxt = ST_RPT_RD;
        end else if (sts.idx_last) begin
          state_nxt = ST_RPT_CLR;
        end else begin
          state_nxt = ST_RPT_SCAN;
        end
      end
      ST_RPT_RD: state_nxt = ST_RPT_DIV;
      ST_RPT_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = ST_RPT_OUT;
        end
      end
      ST_RPT_OUT: begin
        if (sts.out_free) begin
          state_nxt = sts.idx_last ? ST_RPT_CLR : ST_RPT_SCAN;
        end
      end
      ST_RPT_EMPTY: begin
        if (sts.out_free) begin
          state_nxt = ST_RPT_CLR;
        end
      end
      ST_RPT_CLR: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          cmd.idx_clr   = 1'b1;
        end
      end
      ST_OBS_RD: begin
      end
      ST_OBS_CHK: begin
        if (sts.match) begin
          cmd.wr_match = 1'b1;
        end else begin
          cmd.note_empty = 1'b1;
          cmd.idx_inc    = !sts.idx_last;
        end
      end
      ST_OBS_CLAIM: cmd.wr_claim = 1'b1;
      ST_RPT_SCAN: begin
        cmd.idx_inc = sts.occ_any && !sts.occ_cur && !sts.idx_last;
      end
      ST_RPT_RD: cmd.div_start = 1'b1;
      ST_RPT_DIV: begin
      end
      ST_RPT_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.idx_inc  = !sts.idx_last;
        end
      end
      ST_RPT_EMPTY: cmd.out_load_empty = sts.out_free;
      ST_RPT_CLR: cmd.tbl_clear = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/core/neighbour_rssi_average_table_unit.sv
// ----------------------------------------------------------------------------
// neighbour_rssi_average_table_unit: neighbour RSSI average table
// Tracks packet counts and RSSI sums per neighbour id and reports averages.
// ----------------------------------------------------------------------------
// The block keeps TABLE_SLOTS neighbour entries, each holding a node id, a
// packet count and a signed RSSI sum, in a small RAM. An observation item
// (kind 0) scans the slots in order (address, then compare on the registered
// read data) and stops at the first slot whose id equals the sender; there
// it adds the RSSI and bumps the count, restarting both when the count has
// reached 65535. With no match the whole table is scanned and a final claim
// step takes the first slot with id zero; a full table drops the item. A
// sender id of zero accumulates into the first empty slot without claiming
// it. A report item (kind 1) steps through the slots, and for every occupied
// slot does one RAM read, waits on the bit-serial divider that forms the
// average truncated toward zero, and loads the output register, which waits
// there if the output is stalled. The last result of a report carries last;
// an empty table gives a single result with empty_res and last set. A report
// ends with a one-cycle clear of the table, which reset clears as well, so
// no clearing pass is needed after reset. An input transfer is taken only
// while the controller is idle; a finished result may still be waiting on
// the output when the next item is accepted.
// ----------------------------------------------------------------------------
module neighbour_rssi_average_table_unit #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_kind,
  input  logic [nrat_pkg::ID_W-1:0]          in_sender_id,
  input  logic signed [nrat_pkg::RSSI_W-1:0] in_rssi,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [nrat_pkg::ID_W-1:0]          out_node_id,
  output logic signed [nrat_pkg::RSSI_W-1:0] out_avg_rssi,
  output logic                               out_last,
  output logic                               out_empty_res
);
  import nrat_pkg::*;

  // Command and status bundles between the controller and the datapath.
  nrat_cmd_t cmd;
  nrat_sts_t sts;

  // The controller owns the input handshake and the sequencing.
  nrat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // The datapath holds the table, the divider and the output register.
  nrat_dp #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_sender_id  (in_sender_id),
    .in_rssi       (in_rssi),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_node_id   (out_node_id),
    .out_avg_rssi  (out_avg_rssi),
    .out_last      (out_last),
    .out_empty_res (out_empty_res)
  );

endmodule

FILE: tb/sv/tb_neighbour_rssi_average_table_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_neighbour_rssi_average_table_unit: self-checking bench for the RSSI table
// Drives observations and report requests through the valid/stall input,
// keeps its own copy of the neighbour table to predict every report entry,
// and checks each output transfer field by field against the oldest entry
// still owed. Directed tests cover the field extremes, the zero sender id and
// a full table; a random phase follows with bursty input and a varying
// output stall pattern.
// ----------------------------------------------------------------------------
module tb_neighbour_rssi_average_table_unit;
  import nrat_pkg::*;

  localparam int TABLE_SLOTS  = 16;
  localparam int RANDOM_ITEMS = 195;
  localparam int ID_POOL      = 20;   // more ids than slots, so tables do fill
  localparam int DRAIN_CYCLES = 80;   // a full unmatched scan plus the clear
  localparam int MAX_SHOWN    = 10;

  // One report entry as it leaves the block.
  typedef struct packed {
    logic [ID_W-1:0]          node_id;
    logic signed [RSSI_W-1:0] avg_rssi;
    logic                     last;
    logic                     empty_res;
  } nbr_entry_t;

  // Output stall patterns the receiver cycles through.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_LONG
  } stall_mode_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_kind;
  logic [ID_W-1:0]          in_sender_id;
  logic signed [RSSI_W-1:0] in_rssi;
  logic                     out_valid;
  logic                     out_stall;
  logic [ID_W-1:0]          out_node_id;
  logic signed [RSSI_W-1:0] out_avg_rssi;
  logic                     out_last;
  logic                     out_empty_res;

  // The bench's own copy of the neighbour table. A zero id marks a free slot.
  logic [ID_W-1:0]          nbr_id    [TABLE_SLOTS];
  logic [COUNT_W-1:0]       nbr_count [TABLE_SLOTS];
  logic signed [SUM_W-1:0]  nbr_sum   [TABLE_SLOTS];

  // Report entries predicted but not yet seen on the output, oldest first.
  nbr_entry_t owed_entries[$];

  int mismatch_count = 0;
  int burst_left     = 0;
  bit bursty         = 1'b1;

  neighbour_rssi_average_table_unit #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_sender_id  (in_sender_id),
    .in_rssi       (in_rssi),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_node_id   (out_node_id),
    .out_avg_rssi  (out_avg_rssi),
    .out_last      (out_last),
    .out_empty_res (out_empty_res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Table prediction
  // --------------------------------------------------------------------------

  function automatic void nbr_table_clear();
    int i;
    for (i = 0; i < TABLE_SLOTS; i++) begin
      nbr_id[i]    = '0;
      nbr_count[i] = '0;
      nbr_sum[i]   = '0;
    end
  endfunction

  // An observation goes to the first slot holding its sender id. A sender id
  // of zero therefore lands in the first free slot and accumulates there
  // without claiming it. With no match the first free slot is claimed, and a
  // full table drops the observation.
  function automatic void nbr_table_observe(input logic [ID_W-1:0] sender,
                                            input logic signed [RSSI_W-1:0] rssi);
    int i;
    int hit;
    hit = -1;
    for (i = 0; i < TABLE_SLOTS; i++) begin
      if (hit < 0 && nbr_id[i] == sender) hit = i;
    end
    if (hit >= 0) begin
      // A saturated count restarts the running average from this sample.
      if (nbr_count[hit] == COUNT_MAX) begin
        nbr_count[hit] = '0;
        nbr_sum[hit]   = '0;
      end
      nbr_count[hit] = nbr_count[hit] + COUNT_W'(1);
      nbr_sum[hit]   = nbr_sum[hit] + SUM_W'(rssi);
      return;
    end
    for (i = 0; i < TABLE_SLOTS; i++) begin
      if (hit < 0 && nbr_id[i] == '0) hit = i;
    end
    if (hit >= 0) begin
      nbr_id[hit]    = sender;
      nbr_count[hit] = COUNT_W'(1);
      nbr_sum[hit]   = SUM_W'(rssi);
    end
  endfunction

  // A report lists every occupied slot in order with sum / count, truncated
  // toward zero, flags the final entry, and then empties the table. An empty
  // table still gives one entry, flagged both empty and last.
  function automatic void nbr_table_report();
    int         i;
    int         listed;
    int         total;
    int         divisor;
    nbr_entry_t entry;
    listed = 0;
    for (i = 0; i < TABLE_SLOTS; i++) begin
      if (nbr_id[i] != '0) begin
        total   = int'(nbr_sum[i]);
        divisor = int'(nbr_count[i]);
        entry.node_id   = nbr_id[i];
        entry.avg_rssi  = RSSI_W'((divisor == 0) ? 0 : total / divisor);
        entry.last      = 1'b0;
        entry.empty_res = 1'b0;
        owed_entries.push_back(entry);
        listed++;
      end
    end
    if (listed == 0) begin
      entry.node_id   = '0;
      entry.avg_rssi  = '0;
      entry.last      = 1'b1;
      entry.empty_res = 1'b1;
      owed_entries.push_back(entry);
    end else begin
      owed_entries[$].last = 1'b1;
    end
    nbr_table_clear();
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Presents one item and holds it until the block takes it. While bursty is
  // set, input is sent in bursts; when a burst runs out, valid drops for a
  // random gap first. Stall is sampled on the falling edge, where both sides
  // are settled, and the transfer then happens on the next rising edge. The
  // predictor is updated once the transfer has happened, so the item's results
  // are always queued before they can appear.
  task automatic send_item(input logic kind, input logic [ID_W-1:0] sender,
                           input logic signed [RSSI_W-1:0] rssi);
    int gap_len;
    bit taken;
    if (bursty && burst_left == 0) begin
      in_valid <= 1'b0;
      gap_len = $urandom_range(1, 6);
      repeat (gap_len) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_sender_id <= sender;
    in_rssi      <= rssi;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    if (kind == KIND_OBS) nbr_table_observe(sender, rssi);
    else nbr_table_report();
  endtask

  task automatic send_report();
    logic [ID_W-1:0]          junk_id;
    logic signed [RSSI_W-1:0] junk_rssi;
    // The id and RSSI of a report request are ignored, so they carry noise.
    junk_id   = ID_W'($urandom);
    junk_rssi = RSSI_W'($urandom);
    send_item(KIND_RPT, junk_id, junk_rssi);
  endtask

  // --------------------------------------------------------------------------
  // Output side
  // --------------------------------------------------------------------------

  // The receiver changes its stall pattern after each span of random length:
  // no stall at all, occasional stalls, mostly stalled, and long runs of stall
  // and no stall in turn, so stalls land on every stage of a report.
  initial begin : receiver_stall
    stall_mode_t mode;
    int          span;
    int          hold_left;
    logic        hold_val;
    out_stall <= 1'b0;
    hold_left = 0;
    hold_val  = 1'b0;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(10, 60);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default: begin
            if (hold_left == 0) begin
              hold_val  = !hold_val;
              hold_left = $urandom_range(1, 20);
            end
            hold_left--;
            out_stall <= hold_val;
          end
        endcase
      end
    end
  end

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN) $display("%0t ns: %s", $realtime, msg);
  endtask

  task automatic check_field(input string field, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (want !== got) begin
      note_mismatch($sformatf("%s expected %0d, got %0d", field, want, got));
    end
  endtask

  // Every output transfer is matched against the oldest owed entry. Sampling
  // on the falling edge sees exactly what the next rising edge will take.
  always @(negedge clk) begin : entry_check
    nbr_entry_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (owed_entries.size() == 0) begin
        note_mismatch($sformatf("unexpected result, node_id %0d avg_rssi %0d",
                                out_node_id, out_avg_rssi));
      end else begin
        want = owed_entries.pop_front();
        check_field("node_id", want.node_id, out_node_id);
        check_field("avg_rssi", want.avg_rssi, out_avg_rssi);
        check_field("last", want.last, out_last);
        check_field("empty_res", want.empty_res, out_empty_res);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // A report on an empty table, twice in a row, so the second one also
  // follows the clear of the first.
  task automatic test_empty_report();
    send_report();
    send_report();
  endtask

  // Largest and smallest ids and RSSI values, and averages that truncate
  // toward zero on both sides: -255 / 2 gives -127, -3 / 2 gives -1 and
  // 3 / 2 gives 1.
  task automatic test_field_extremes();
    send_item(KIND_OBS, 16'hFFFF, 8'sd127);
    send_item(KIND_OBS, 16'h0001, -8'sd128);
    send_item(KIND_OBS, 16'hFFFF, 8'sd127);
    send_item(KIND_OBS, 16'h0001, -8'sd127);
    send_item(KIND_OBS, 16'h8000, -8'sd1);
    send_item(KIND_OBS, 16'h8000, -8'sd2);
    send_item(KIND_OBS, 16'h7FFF, 8'sd1);
    send_item(KIND_OBS, 16'h7FFF, 8'sd2);
    send_report();
  endtask

  // A zero sender id fills the first free slot without occupying it: alone
  // it leaves an empty report, and a later new sender overwrites that slot's
  // count and sum when it claims it.
  task automatic test_zero_sender();
    send_item(KIND_OBS, 16'h0000, 8'sd10);
    send_report();
    send_item(KIND_OBS, 16'h0042, -8'sd20);
    send_item(KIND_OBS, 16'h0000, 8'sd60);
    send_item(KIND_OBS, 16'h0000, 8'sd60);
    send_item(KIND_OBS, 16'h00A5, -8'sd5);
    send_report();
  endtask

  // Sixteen distinct ids fill every slot, a seventeenth is dropped, and a
  // repeat of the last id still matches. The report then has the most
  // entries a report can have.
  task automatic test_full_table();
    int                       i;
    logic [ID_W-1:0]          sender;
    logic signed [RSSI_W-1:0] rssi;
    for (i = 0; i <= TABLE_SLOTS; i++) begin
      // The low bits keep the ids distinct, the random high bits keep them
      // nonzero.
      sender = {11'($urandom_range(1, 2047)), 5'(i)};
      rssi   = RSSI_W'($urandom);
      send_item(KIND_OBS, sender, rssi);
    end
    rssi = RSSI_W'($urandom);
    send_item(KIND_OBS, nbr_id[TABLE_SLOTS-1], rssi);
    send_report();
  endtask

  // Random traffic in segments. Each segment picks its own report rate, so
  // some tables stay sparse and others fill up and drop senders, and some
  // segments send without gaps. Most observations reuse a pool of ids so
  // that entries collect several samples.
  task automatic test_random_traffic();
    int                       i;
    int                       pick;
    int                       report_pct;
    logic [ID_W-1:0]          id_pool [ID_POOL];
    logic [ID_W-1:0]          sender;
    logic signed [RSSI_W-1:0] rssi;
    for (i = 0; i < ID_POOL; i++) id_pool[i] = ID_W'($urandom_range(1, 65535));
    id_pool[0] = '1;
    id_pool[1] = 16'h0001;
    report_pct = 9;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) begin
        bursty = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 2))
          0:       report_pct = 2;
          1:       report_pct = 9;
          default: report_pct = 20;
        endcase
      end
      pick = $urandom_range(0, 99);
      rssi = RSSI_W'($urandom);
      if (pick < report_pct) begin
        send_report();
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 4) sender = '0;
        else if (pick < 12) sender = ID_W'($urandom);
        else sender = id_pool[$urandom_range(0, ID_POOL - 1)];
        send_item(KIND_OBS, sender, rssi);
      end
    end
    send_report();
    bursty = 1'b1;
  endtask

  // Drops valid, waits for every owed entry, then lets the block finish its
  // table clear before the verdict.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (owed_entries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_kind      <= KIND_OBS;
    in_sender_id <= '0;
    in_rssi      <= '0;
    nbr_table_clear();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_report();
    test_field_extremes();
    test_zero_sender();
    test_full_table();
    test_random_traffic();
    drain_results();

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Even if every item were a full report under the longest stalls, a run
  // would finish well within this timeout.
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/nrat_pkg.sv
rtl/core/nrat_ram.sv
rtl/core/nrat_div.sv
rtl/core/nrat_dp.sv
rtl/core/nrat_ctrl.sv
rtl/core/neighbour_rssi_average_table_unit.sv
tb/sv/tb_neighbour_rssi_average_table_unit.sv
